[hdl/four_channel_sound_generator_core_assert.svh]
// Assertion macros shared by the sound generator RTL.
`ifndef FOUR_CHANNEL_SOUND_GENERATOR_CORE_ASSERT_SVH
`define FOUR_CHANNEL_SOUND_GENERATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FCSG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FCSG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FCSG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FCSG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/fcsg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fcsg_pkg;
  localparam int unsigned MaxCycles = 31;
  localparam int unsigned FrameDivider = 8192;
  localparam logic [10:0] FreqMax = 11'd2047;
  localparam logic [7:0] TrigBit = 8'h80;
  localparam logic [7:0] LenEnBit = 8'h40;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CYCLE = 2'd2,
    CMD_EMIT  = 2'd3
  } dp_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    dp_op_t     op;
    logic [5:0] addr;
    logic [7:0] data;
  } dp_cmd_t;

  // Pulse duty waveform, indexed by duty code and step.
  function automatic logic duty_bit(input logic [1:0] d, input logic [2:0] s);
    logic [7:0] row;
    begin
      case (d)
        2'd0: row = 8'b1000_0000;
        2'd1: row = 8'b1000_0001;
        2'd2: row = 8'b1110_0001;
        default: row = 8'b0111_1110;
      endcase
      duty_bit = row[s];
    end
  endfunction
endpackage
`default_nettype wire

[hdl/four_channel_sound_generator_core.sv]
// A write item goes to the datapath as it is accepted; a time item then runs
// one clock per emulated machine cycle in the channel datapath, then a sample check.
// Items are taken one at a time; a new one is not accepted until the last is through.
// The result sits in an output register; the next item also waits while it is unread.
// Reset: synchronous, active-low rst_n clears all state; the interval resets to 95.
`timescale 1ns / 1ps
`default_nettype none
module four_channel_sound_generator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cmd[0], reg_addr[6:1], write_data[14:7], cycles[19:15], zero fill
  input  wire logic [23:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // mix_level[5:0], channels_on[9:6], zero fill
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import fcsg_pkg::*;

  logic [15:0] interval_r;
  dp_cmd_t     cmd;

  // Sample interval register.
  always_ff @(posedge clk) begin
    if (!rst_n) interval_r <= 16'd95;
    else if (cfg_we) interval_r <= cfg_wdata;
  end

  fcsg_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata[19:0]), .out_busy(out_tvalid && !out_tready),
    .cfg_interval(interval_r), .cmd(cmd)
  );

  fcsg_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata)
  );
endmodule
`default_nettype wire

[hdl/fcsg_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "four_channel_sound_generator_core_assert.svh"
module fcsg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [19:0]       in_tdata,
  input  wire logic              out_busy,
  input  wire logic [15:0]       cfg_interval,
  output fcsg_pkg::dp_cmd_t      cmd
);
  import fcsg_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_CHECK} state_t;

  state_t      state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        go;
  logic [15:0] ivl;
  logic [16:0] sum;

  assign in_tready = (state_r == S_IDLE) && !out_busy;
  assign go = in_tvalid && in_tready;
  assign ivl = (cfg_interval == 16'd0) ? 16'd1 : cfg_interval;
  assign sum = {1'b0, acc_r} + {12'd0, cnt_r};

  // Sequencer: writes pass straight on; time items run one emulated cycle per clock, then the sample check.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    cmd = '{op: CMD_NONE, addr: in_tdata[6:1], data: in_tdata[14:7]};
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          if (!in_tdata[0]) begin
            cmd.op = CMD_WRITE;
          end else begin
            cnt_nxt = in_tdata[19:15];
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (cnt_r == 5'd0) begin
          state_nxt = S_CHECK;
        end else begin
          cmd.op = CMD_CYCLE;
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        if (sum > {1'b0, ivl}) begin
          cmd.op = CMD_EMIT;
          acc_nxt = 16'(sum - {1'b0, ivl});
        end else begin
          acc_nxt = sum[15:0];
        end
      end
    endcase
  end

  // The cycle count doubles as the accumulator addend in the check state.
  logic [4:0] run_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      acc_r <= '0;
      run_r <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r <= acc_nxt;
      if (go && in_tdata[0]) begin
        run_r <= in_tdata[19:15];
      end
      cnt_r <= (state_nxt == S_CHECK) ? run_r : cnt_nxt;
    end
  end

  `FCSG_ASSERT_NXT(a_run_after_time, clk, rst_n, go && in_tdata[0], state_r == S_RUN)
  `FCSG_ASSERT_IMP(a_no_take_busy, clk, rst_n, state_r != S_IDLE, !in_tready)
  `FCSG_ASSERT_IMP(a_emit_in_check, clk, rst_n, cmd.op == CMD_EMIT, state_r == S_CHECK)
endmodule
`default_nettype wire

[hdl/fcsg_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "four_channel_sound_generator_core_assert.svh"
module fcsg_datapath (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  fcsg_pkg::dp_cmd_t cmd,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [15:0]       out_tdata
);
  import fcsg_pkg::*;

  logic [7:0]  regs_r [20];
  logic [7:0]  wave_r [16];
  logic [21:0] tmr_r [4];
  logic [4:0]  pos_r [3];
  logic [8:0]  len_r [4];
  logic [3:0]  vol_r [3];
  logic [2:0]  ecnt_r [3];
  logic [2:0]  eact_r;
  logic [2:0]  swc_r;
  logic [10:0] shadow_r;
  logic [14:0] lfsr_r;
  logic [3:0]  en_r;
  logic [12:0] fcnt_r;
  logic [2:0]  fstep_r;

  // Channel register helpers.
  function automatic logic [10:0] freq_of(input logic [7:0] lo, input logic [7:0] hi);
    freq_of = {hi[2:0], lo};
  endfunction

  logic [21:0] rel [4];
  logic [2:0]  nr43_r;
  logic [4:0]  nz_div;
  logic [11:0] sw_sum;
  logic [11:0] sw_sum_tr;
  logic        sw_upd;
  logic [10:0] f0;

  // A sweep update in the same cycle feeds the new frequency to the pulse timer reload.
  always_comb begin
    f0 = sw_upd ? sw_sum[10:0] : freq_of(regs_r[3], regs_r[4]);
    rel[0] = {9'd0, 11'(12'd2048 - {1'b0, f0}), 2'b00};
    rel[1] = {9'd0, 11'(12'd2048 - {1'b0, freq_of(regs_r[8], regs_r[9])}), 2'b00};
    rel[2] = {10'd0, 11'(12'd2048 - {1'b0, freq_of(regs_r[13], regs_r[14])}), 1'b0};
    if (f0 == 11'd0) rel[0] = 22'd8192;
    if (freq_of(regs_r[8], regs_r[9]) == 11'd0) rel[1] = 22'd8192;
    if (freq_of(regs_r[13], regs_r[14]) == 11'd0) rel[2] = 22'd4096;
    nr43_r = regs_r[18][2:0];
    nz_div = (nr43_r == 3'd0) ? 5'd8 : 5'd0;
    rel[3] = (nr43_r == 3'd0) ? (22'(nz_div) << regs_r[18][7:4])
                              : (22'({nr43_r, 4'd0}) << regs_r[18][7:4]);
  end

  // Sweep arithmetic on the shadow frequency.
  function automatic logic [11:0] sweep_of(input logic [10:0] f, input logic [7:0] nr10);
    logic [11:0] d;
    begin
      d = {1'b0, f >> nr10[2:0]};
      sweep_of = nr10[3] ? ({1'b0, f} - d) : ({1'b0, f} + d);
    end
  endfunction

  assign sw_sum = sweep_of(shadow_r, regs_r[0]);
  assign sw_sum_tr = sweep_of(sw_sum[10:0], regs_r[0]);

  // Mixer.
  logic [3:0] co [4];
  logic [7:0] wb;
  logic [3:0] nib;
  logic [5:0] mix;
  always_comb begin
    co[0] = (en_r[0] && duty_bit(regs_r[1][7:6], pos_r[0][2:0])) ? vol_r[0] : 4'd0;
    co[1] = (en_r[1] && duty_bit(regs_r[6][7:6], pos_r[1][2:0])) ? vol_r[1] : 4'd0;
    wb = wave_r[pos_r[2][4:1]];
    nib = pos_r[2][0] ? wb[3:0] : wb[7:4];
    case (regs_r[12][6:5])
      2'd0: co[2] = 4'd0;
      2'd1: co[2] = nib;
      2'd2: co[2] = nib >> 1;
      default: co[2] = nib >> 2;
    endcase
    if (!en_r[2]) co[2] = 4'd0;
    co[3] = (en_r[3] && !lfsr_r[0]) ? vol_r[2] : 4'd0;
    mix = 6'(co[0]) + 6'(co[1]) + 6'(co[2]) + 6'(co[3]);
  end

  logic       wr, tick, fclk;
  logic [2:0] fstep_n;
  logic [4:0] ch;
  logic [2:0] rg;
  logic [4:0] ra;
  assign wr = cmd.op == CMD_WRITE;
  assign tick = cmd.op == CMD_CYCLE;
  assign fclk = tick && (fcnt_r == 13'(FrameDivider - 1));
  assign fstep_n = fstep_r + 3'd1;
  assign ra = cmd.addr[4:0];
  assign sw_upd = fclk && (fstep_n == 3'd2 || fstep_n == 3'd6) && swc_r == 3'd1 &&
                  regs_r[0][6:4] != 3'd0 && sw_sum <= 12'(FreqMax) &&
                  regs_r[0][2:0] != 3'd0;
  always_comb begin
    ch = '0;
    rg = '0;
    if (ra < 5'd5) begin
      ch = 5'd0; rg = 3'(ra);
    end else if (ra < 5'd10) begin
      ch = 5'd1; rg = 3'(ra - 5'd5);
    end else if (ra < 5'd15) begin
      ch = 5'd2; rg = 3'(ra - 5'd10);
    end else begin
      ch = 5'd3; rg = 3'(ra - 5'd15);
    end
  end

  logic       reg_wr;
  assign reg_wr = wr && cmd.addr < 6'd20;

  logic [14:0] lfsr_nx;
  logic        lx;
  assign lx = lfsr_r[0] ^ lfsr_r[1];
  always_comb begin
    lfsr_nx = {lx, lfsr_r[14:1]};
    if (regs_r[18][3]) lfsr_nx[6] = lx;
  end

  // Channel state and output: writes, triggers, per-cycle timers, frame clocks and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 20; i++) regs_r[i] <= '0;
      for (int i = 0; i < 16; i++) wave_r[i] <= '0;
      for (int i = 0; i < 4; i++) begin
        tmr_r[i] <= '0;
        len_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vol_r[i] <= '0;
        ecnt_r[i] <= '0;
      end
      eact_r <= '0;
      swc_r <= '0;
      shadow_r <= '0;
      lfsr_r <= '0;
      en_r <= '0;
      fcnt_r <= '0;
      fstep_r <= '0;
      out_tvalid <= 1'b0;
      out_tdata <= '0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      if (cmd.op == CMD_EMIT) begin
        out_tvalid <= 1'b1;
        out_tdata <= {6'd0, en_r, mix};
      end
      if (wr && cmd.addr >= 6'd32 && cmd.addr < 6'd48) wave_r[cmd.addr[3:0]] <= cmd.data;
      if (reg_wr) begin
        regs_r[ra] <= cmd.data;
        if (rg == 3'd1)
          len_r[ch[1:0]] <= (ch == 5'd2) ? 9'(9'd256 - {1'b0, cmd.data})
                                       : 9'(7'd64 - {1'b0, cmd.data[5:0]});
        if (rg == 3'd4 && (cmd.data & TrigBit) != 8'd0) begin
          en_r[ch[1:0]] <= 1'b1;
          if (len_r[ch[1:0]] == 9'd0) len_r[ch[1:0]] <= (ch == 5'd2) ? 9'd256 : 9'd64;
          if (ch < 5'd3) pos_r[ch[1:0]] <= '0;
          // The trigger reload uses the new frequency high bits.
          unique case (ch[1:0])
            2'd0: begin
              tmr_r[0] <= {9'd0, 11'(12'd2048 - {1'b0, cmd.data[2:0], regs_r[3]}), 2'b00}
                          | ((cmd.data[2:0] == 3'd0 && regs_r[3] == 8'd0) ? 22'd8192 : 22'd0);
              vol_r[0] <= regs_r[2][7:4];
              ecnt_r[0] <= regs_r[2][2:0];
              eact_r[0] <= 1'b1;
              shadow_r <= {cmd.data[2:0], regs_r[3]};
              swc_r <= regs_r[0][6:4];
              if (regs_r[0][2:0] != 3'd0 &&
                  sweep_of({cmd.data[2:0], regs_r[3]}, regs_r[0]) > 12'(FreqMax))
                en_r[0] <= 1'b0;
            end
            2'd1: begin
              tmr_r[1] <= {9'd0, 11'(12'd2048 - {1'b0, cmd.data[2:0], regs_r[8]}), 2'b00}
                          | ((cmd.data[2:0] == 3'd0 && regs_r[8] == 8'd0) ? 22'd8192 : 22'd0);
              vol_r[1] <= regs_r[7][7:4];
              ecnt_r[1] <= regs_r[7][2:0];
              eact_r[1] <= 1'b1;
            end
            2'd2: begin
              tmr_r[2] <= {10'd0, 11'(12'd2048 - {1'b0, cmd.data[2:0], regs_r[13]}), 1'b0}
                          | ((cmd.data[2:0] == 3'd0 && regs_r[13] == 8'd0) ? 22'd4096 : 22'd0);
            end
            default: begin
              tmr_r[3] <= rel[3];
              vol_r[2] <= regs_r[17][7:4];
              ecnt_r[2] <= regs_r[17][2:0];
              eact_r[2] <= 1'b1;
              lfsr_r <= 15'h7FFF;
            end
          endcase
        end
      end
      if (tick) begin
        fcnt_r <= fclk ? 13'd0 : fcnt_r + 13'd1;
        if (fclk) begin
          fstep_r <= fstep_n;
          if (!fstep_n[0]) begin
            for (int c = 0; c < 4; c++) begin
              if (regs_r[c * 5 + 4][6] && len_r[c] != 9'd0) begin
                len_r[c] <= len_r[c] - 9'd1;
                if (len_r[c] == 9'd1) en_r[c] <= 1'b0;
              end
            end
          end
          if (fstep_n == 3'd2 || fstep_n == 3'd6) begin
            swc_r <= swc_r - 3'd1;
            if (swc_r == 3'd1) begin
              swc_r <= regs_r[0][6:4];
              if (regs_r[0][6:4] != 3'd0) begin
                if (sw_sum > 12'(FreqMax)) begin
                  en_r[0] <= 1'b0;
                end else if (regs_r[0][2:0] != 3'd0) begin
                  shadow_r <= sw_sum[10:0];
                  regs_r[3] <= sw_sum[7:0];
                  regs_r[4] <= {regs_r[4][7:3], sw_sum[10:8]};
                  if (sw_sum_tr > 12'(FreqMax)) en_r[0] <= 1'b0;
                end
              end
            end
          end
          if (fstep_n == 3'd7) begin
            for (int e = 0; e < 3; e++) begin
              if (eact_r[e] && regs_r[(e == 2 ? 3 : e) * 5 + 2][2:0] != 3'd0) begin
                ecnt_r[e] <= ecnt_r[e] - 3'd1;
                if (ecnt_r[e] == 3'd1) begin
                  ecnt_r[e] <= regs_r[(e == 2 ? 3 : e) * 5 + 2][2:0];
                  if (regs_r[(e == 2 ? 3 : e) * 5 + 2][3] && vol_r[e] != 4'd15)
                    vol_r[e] <= vol_r[e] + 4'd1;
                  else if (!regs_r[(e == 2 ? 3 : e) * 5 + 2][3] && vol_r[e] != 4'd0)
                    vol_r[e] <= vol_r[e] - 4'd1;
                  else
                    eact_r[e] <= 1'b0;
                end
              end
            end
          end
        end
        for (int c = 0; c < 4; c++) begin
          if (tmr_r[c] > 22'd1) begin
            tmr_r[c] <= tmr_r[c] - 22'd1;
          end else begin
            tmr_r[c] <= rel[c];
            if (c < 2) pos_r[c] <= {2'b00, 3'(pos_r[c][2:0] + 3'd1)};
            else if (c == 2) pos_r[2] <= pos_r[2] + 5'd1;
            else if (regs_r[18][7:4] < 4'd14) lfsr_r <= lfsr_nx;
          end
        end
      end
    end
  end

  `FCSG_ASSERT_IMP(a_mix_range, clk, rst_n, out_tvalid, out_tdata[5:0] <= 6'd60)
  `FCSG_ASSERT_IMP(a_no_emit_while_full, clk, rst_n, cmd.op == CMD_EMIT, !out_tvalid || out_tready)
  `FCSG_ASSERT_IMP(a_frame_count, clk, rst_n, 1'b1, fcnt_r <= 13'(FrameDivider - 1))
endmodule
`default_nettype wire
